// ===== rtl/core/bbag_pkg.sv =====
// ----------------------------------------------------------------------------
// bbag_pkg
// Shared widths, register indexes and the result record of the banked
// bitmap blit address generator.
// ----------------------------------------------------------------------------
package bbag_pkg;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam int PIX_W      = 8;
  localparam int SRC_ADDR_W = 24;
  localparam int DST_ADDR_W = 32;
  localparam int STRIDE_W   = 16;
  localparam int BANK_W     = 8;
  localparam int OFS_W      = 16;

  localparam int S_TDATA_W  = 8;
  localparam int M_TDATA_W  = BANK_W + OFS_W + DST_ADDR_W + PIX_W;

  // Register indexes on the configuration port
  localparam logic [CFG_ADDR_W-1:0] REG_SRC_START  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SRC_STRIDE = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_WIDTH      = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_HEIGHT     = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_DST_START  = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_DST_STRIDE = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_TRANSPARENT = 3'd6;

  typedef struct packed {
    logic [BANK_W-1:0]     src_bank;
    logic [OFS_W-1:0]      src_offset;
    logic [DST_ADDR_W-1:0] dst_addr;
    logic [PIX_W-1:0]      pixel_out;
    logic                  write_enable;
    logic                  last;
  } bbag_result_t;

endpackage

// ===== rtl/core/bbag_step.sv =====
// ----------------------------------------------------------------------------
// bbag_step
// Per-pixel address step: forms the source bank/offset, canvas address,
// write enable and last flag, and the walker state for the next pixel.
// ----------------------------------------------------------------------------
module bbag_step
  import bbag_pkg::*;
#(
  parameter int BANK_OFFSET_BITS = 16,
  parameter int DIM_BITS         = 12
) (
  input  logic [PIX_W-1:0]      pixel,
  input  logic [SRC_ADDR_W-1:0] src_start,
  input  logic [STRIDE_W-1:0]   src_stride,
  input  logic [DIM_BITS-1:0]   width,
  input  logic [DIM_BITS-1:0]   height,
  input  logic [DST_ADDR_W-1:0] dst_start,
  input  logic [STRIDE_W-1:0]   dst_stride,
  input  logic                  transparent_mode,
  input  logic [DIM_BITS-1:0]   column_count,
  input  logic [DIM_BITS-1:0]   row_count,
  input  logic [SRC_ADDR_W-1:0] row_src_addr,
  input  logic [DST_ADDR_W-1:0] row_dst_addr,
  output bbag_result_t          result,
  output logic [DIM_BITS-1:0]   column_count_next,
  output logic [DIM_BITS-1:0]   row_count_next,
  output logic [SRC_ADDR_W-1:0] row_src_addr_next,
  output logic [DST_ADDR_W-1:0] row_dst_addr_next
);

  localparam logic [31:0] OFS_MASK = (32'd1 << BANK_OFFSET_BITS) - 32'd1;

  logic                  empty;
  logic                  first_row;
  logic [SRC_ADDR_W-1:0] base_src;
  logic [DST_ADDR_W-1:0] base_dst;
  logic [DIM_BITS-1:0]   col;
  logic [SRC_ADDR_W-1:0] saddr;
  logic [31:0]           saddr_ext;
  logic [31:0]           bank_shift;
  logic [31:0]           ofs_ext;
  logic [DIM_BITS:0]     col_inc;
  logic [DIM_BITS:0]     row_inc;
  logic                  row_end;
  logic                  last;

  always_comb begin
    empty     = (width == '0) || (height == '0);
    first_row = (row_count == '0) || empty;
    base_src  = first_row ? src_start : row_src_addr;
    base_dst  = first_row ? dst_start : row_dst_addr;
    col       = empty ? '0 : column_count;

    saddr      = base_src + SRC_ADDR_W'(col);
    saddr_ext  = 32'(saddr);
    bank_shift = saddr_ext >> BANK_OFFSET_BITS;
    ofs_ext    = saddr_ext & OFS_MASK;

    col_inc = {1'b0, column_count} + {{DIM_BITS{1'b0}}, 1'b1};
    row_inc = {1'b0, row_count} + {{DIM_BITS{1'b0}}, 1'b1};
    row_end = empty || (col_inc >= {1'b0, width});
    last    = row_end && (empty || (row_inc >= {1'b0, height}));

    result.src_bank     = bank_shift[BANK_W-1:0];
    result.src_offset   = ofs_ext[OFS_W-1:0];
    result.dst_addr     = base_dst + DST_ADDR_W'(col);
    result.pixel_out    = pixel;
    result.write_enable = !empty && (!transparent_mode || (pixel != '0));
    result.last         = last;

    // Default: hold row bases, advance the column
    column_count_next = col_inc[DIM_BITS-1:0];
    row_count_next    = row_count;
    row_src_addr_next = row_src_addr;
    row_dst_addr_next = row_dst_addr;
    if (last) begin
      column_count_next = '0;
      row_count_next    = '0;
    end else if (row_end) begin
      column_count_next = '0;
      row_count_next    = row_inc[DIM_BITS-1:0];
      row_src_addr_next = base_src + SRC_ADDR_W'(src_stride);
      row_dst_addr_next = base_dst + DST_ADDR_W'(dst_stride);
    end
  end

endmodule

// ===== rtl/core/banked_bitmap_blit_address_gen.sv =====
// ----------------------------------------------------------------------------
// banked_bitmap_blit_address_gen
// Walks a width-by-height bitmap in row-major order and gives, per pixel,
// the banked source address, the canvas address and a write enable.
// ----------------------------------------------------------------------------
// Path: an accepted request passes the input register, the address step,
//   then the result register.
// Throughput: one pixel per cycle while m_tready is high, set by the
//   combinational address step between the two registers; s_tready follows
//   m_tready directly, so a stall downstream costs no bubble when it clears.
// Reset: rst (synchronous) empties both registers, zeroes the walker state
//   and returns every configuration register to zero.
// ----------------------------------------------------------------------------
module banked_bitmap_blit_address_gen
  import bbag_pkg::*;
#(
  parameter int BANK_OFFSET_BITS = 16,
  parameter int DIM_BITS         = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  // Configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // Pixel stream in
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [S_TDATA_W-1:0]  s_tdata,   // [7:0] pixel
  // Address stream out
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [M_TDATA_W-1:0]  m_tdata,   // [7:0] src_bank, [23:8] src_offset,
                                           // [55:24] dst_addr, [63:56] pixel_out
  output logic                  m_tuser,   // write_enable
  output logic                  m_tlast    // last pixel of the bitmap
);

  // Configuration registers
  logic [SRC_ADDR_W-1:0] src_start;
  logic [STRIDE_W-1:0]   src_stride;
  logic [DIM_BITS-1:0]   width;
  logic [DIM_BITS-1:0]   height;
  logic [DST_ADDR_W-1:0] dst_start;
  logic [STRIDE_W-1:0]   dst_stride;
  logic                  transparent_mode;

  // Walker state
  logic [DIM_BITS-1:0]   column_count;
  logic [DIM_BITS-1:0]   row_count;
  logic [SRC_ADDR_W-1:0] row_src_addr;
  logic [DST_ADDR_W-1:0] row_dst_addr;
  logic [DIM_BITS-1:0]   column_count_next;
  logic [DIM_BITS-1:0]   row_count_next;
  logic [SRC_ADDR_W-1:0] row_src_addr_next;
  logic [DST_ADDR_W-1:0] row_dst_addr_next;

  // Pipeline registers
  logic                  in_valid;
  logic [PIX_W-1:0]      in_pixel;
  logic                  out_valid;
  bbag_result_t          out_result;
  bbag_result_t          step_result;
  logic                  advance;

  // Register writes; indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      src_start        <= '0;
      src_stride       <= '0;
      width            <= '0;
      height           <= '0;
      dst_start        <= '0;
      dst_stride       <= '0;
      transparent_mode <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_SRC_START:   src_start        <= cfg_wdata[SRC_ADDR_W-1:0];
        REG_SRC_STRIDE:  src_stride       <= cfg_wdata[STRIDE_W-1:0];
        REG_WIDTH:       width            <= cfg_wdata[DIM_BITS-1:0];
        REG_HEIGHT:      height           <= cfg_wdata[DIM_BITS-1:0];
        REG_DST_START:   dst_start        <= cfg_wdata[DST_ADDR_W-1:0];
        REG_DST_STRIDE:  dst_stride       <= cfg_wdata[STRIDE_W-1:0];
        REG_TRANSPARENT: transparent_mode <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // Move the held request into the result register whenever that register
  // is empty or being drained this cycle; the input register refills at once.
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_pixel <= s_tdata[PIX_W-1:0];
    end
  end

  bbag_step #(
    .BANK_OFFSET_BITS (BANK_OFFSET_BITS),
    .DIM_BITS         (DIM_BITS)
  ) u_step (
    .pixel             (in_pixel),
    .src_start         (src_start),
    .src_stride        (src_stride),
    .width             (width),
    .height            (height),
    .dst_start         (dst_start),
    .dst_stride        (dst_stride),
    .transparent_mode  (transparent_mode),
    .column_count      (column_count),
    .row_count         (row_count),
    .row_src_addr      (row_src_addr),
    .row_dst_addr      (row_dst_addr),
    .result            (step_result),
    .column_count_next (column_count_next),
    .row_count_next    (row_count_next),
    .row_src_addr_next (row_src_addr_next),
    .row_dst_addr_next (row_dst_addr_next)
  );

  // Walker state advances exactly once per request handed on
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      row_src_addr <= '0;
      row_dst_addr <= '0;
    end else if (advance) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
      row_src_addr <= row_src_addr_next;
      row_dst_addr <= row_dst_addr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= step_result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_result.pixel_out, out_result.dst_addr,
                     out_result.src_offset, out_result.src_bank};
  assign m_tuser  = out_result.write_enable;
  assign m_tlast  = out_result.last;

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the banked bitmap blit address generator. A short
// directed table of register writes and pixel requests comes first, then
// random blits with random register settings and random idle on both the
// pixel and the address streams. Every result is compared, field by field,
// with a hand-written expectation or an in-bench model of the address walker.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bbag_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int RST_CYCLES     = 4;
  localparam int RAND_PIXELS    = 750;
  localparam int HOLD_CYCLES    = 120;   // long back-pressure stretch on the address side
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transfer at all
  localparam int TAIL_CYCLES    = 10;    // result path is two registers deep
  localparam int DIM_W          = 12;
  localparam int BANK_SHIFT     = 16;    // offset bits inside one bank window

  // Index past the end of the register list; writes to it must be ignored
  localparam logic [CFG_ADDR_W-1:0] REG_NONE = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata;    // [7:0] pixel
  logic                  m_tvalid;
  logic                  m_tready;
  logic [M_TDATA_W-1:0]  m_tdata;    // [7:0] src_bank, [23:8] src_offset,
                                     // [55:24] dst_addr, [63:56] pixel_out
  logic                  m_tuser;    // write_enable
  logic                  m_tlast;    // last pixel of the bitmap

  banked_bitmap_blit_address_gen dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // --------------------------------------------------------------------------
  // Bench copy of the blit registers and of the walker state
  // --------------------------------------------------------------------------
  typedef struct packed {
    logic [SRC_ADDR_W-1:0] src_start;
    logic [STRIDE_W-1:0]   src_stride;
    logic [DIM_W-1:0]      width;
    logic [DIM_W-1:0]      height;
    logic [DST_ADDR_W-1:0] dst_start;
    logic [STRIDE_W-1:0]   dst_stride;
    logic                  transparent;
  } blit_regs_t;

  blit_regs_t            regs;
  logic [DIM_W-1:0]      col_cnt;
  logic [DIM_W-1:0]      row_cnt;
  logic [SRC_ADDR_W-1:0] row_src;
  logic [DST_ADDR_W-1:0] row_dst;

  bbag_result_t pending_q[$];   // addresses still owed by the block, oldest first
  int           errors = 0;
  int           idle_cycles = 0;
  bit           no_idle = 1'b0; // calm phase: neither side inserts gaps
  bit           hold_req = 1'b0;

  // --------------------------------------------------------------------------
  // Directed table: register writes and pixel requests, in order
  // --------------------------------------------------------------------------
  typedef enum logic {ROW_REG, ROW_PIX} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_ADDR_W-1:0] idx;
    logic [CFG_DATA_W-1:0] val;
    logic [PIX_W-1:0]      pix;
    logic                  typed;   // expected result written out by hand
    bbag_result_t          known;
  } stim_row_t;

  stim_row_t directed_q[$];

  function automatic void add_reg(input logic [CFG_ADDR_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
    stim_row_t r;
    r      = '0;
    r.kind = ROW_REG;
    r.idx  = idx;
    r.val  = val;
    directed_q.push_back(r);
  endfunction

  function automatic void add_pix(input logic [PIX_W-1:0] pix);
    stim_row_t r;
    r      = '0;
    r.kind = ROW_PIX;
    r.pix  = pix;
    directed_q.push_back(r);
  endfunction

  function automatic void add_known(input logic [PIX_W-1:0] pix, input logic [BANK_W-1:0] bank,
                                    input logic [OFS_W-1:0] ofs,
                                    input logic [DST_ADDR_W-1:0] dst,
                                    input logic we, input logic fin);
    stim_row_t r;
    r                    = '0;
    r.kind               = ROW_PIX;
    r.pix                = pix;
    r.typed              = 1'b1;
    r.known.src_bank     = bank;
    r.known.src_offset   = ofs;
    r.known.dst_addr     = dst;
    r.known.pixel_out    = pix;
    r.known.write_enable = we;
    r.known.last         = fin;
    directed_q.push_back(r);
  endfunction

  // --------------------------------------------------------------------------
  // Address walker model: one pixel in, one address record out
  // --------------------------------------------------------------------------
  function automatic void note_reg(input logic [CFG_ADDR_W-1:0] idx,
                                   input logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_SRC_START:   regs.src_start   = val[SRC_ADDR_W-1:0];
      REG_SRC_STRIDE:  regs.src_stride  = val[STRIDE_W-1:0];
      REG_WIDTH:       regs.width       = val[DIM_W-1:0];
      REG_HEIGHT:      regs.height      = val[DIM_W-1:0];
      REG_DST_START:   regs.dst_start   = val[DST_ADDR_W-1:0];
      REG_DST_STRIDE:  regs.dst_stride  = val[STRIDE_W-1:0];
      REG_TRANSPARENT: regs.transparent = val[0];
      default: ;
    endcase
  endfunction

  function automatic bbag_result_t blit_step(input logic [PIX_W-1:0] pix);
    bbag_result_t          res;
    logic                  empty;
    logic                  first_row;
    logic                  row_end;
    logic                  fin;
    logic [SRC_ADDR_W-1:0] base_src;
    logic [SRC_ADDR_W-1:0] saddr;
    logic [DST_ADDR_W-1:0] base_dst;
    logic [DST_ADDR_W-1:0] daddr;
    logic [DIM_W-1:0]      col;

    // A zero-sized bitmap gives the start position on every request
    empty     = (regs.width == '0) || (regs.height == '0);
    first_row = (row_cnt == '0) || empty;
    base_src  = first_row ? regs.src_start : row_src;
    base_dst  = first_row ? regs.dst_start : row_dst;
    col       = empty ? '0 : col_cnt;
    saddr     = base_src + SRC_ADDR_W'(col);   // wraps at 24 bits
    daddr     = base_dst + DST_ADDR_W'(col);   // wraps at 32 bits

    // Compare one bit wider so a counter at its top does not wrap to zero;
    // a width or height lowered mid-blit ends the row or the bitmap at once
    row_end = empty || (({1'b0, col_cnt} + 1'b1) >= {1'b0, regs.width});
    fin     = row_end && (empty || (({1'b0, row_cnt} + 1'b1) >= {1'b0, regs.height}));

    res.src_bank     = BANK_W'(saddr >> BANK_SHIFT);
    res.src_offset   = saddr[OFS_W-1:0];
    res.dst_addr     = daddr;
    res.pixel_out    = pix;
    res.write_enable = !empty && (!regs.transparent || (pix != '0));
    res.last         = fin;

    if (fin) begin
      col_cnt = '0;
      row_cnt = '0;
    end else if (row_end) begin
      col_cnt = '0;
      row_cnt = row_cnt + 1'b1;
      row_src = base_src + SRC_ADDR_W'(regs.src_stride);
      row_dst = base_dst + DST_ADDR_W'(regs.dst_stride);
    end else begin
      col_cnt = col_cnt + 1'b1;
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Random helpers
  // --------------------------------------------------------------------------
  // Gap length: mostly none, some short, a few long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    else if (r < 94) return $urandom_range(1, 3);
    else return $urandom_range(8, 40);
  endfunction

  // Register value with junk above the register width; favour bank edges,
  // address wrap, zero and full strides, and small bitmaps
  function automatic logic [CFG_DATA_W-1:0] reg_value(input logic [CFG_ADDR_W-1:0] idx);
    logic [CFG_DATA_W-1:0] junk;
    int                    r;
    junk = $urandom;
    r    = $urandom_range(0, 15);
    case (idx)
      REG_SRC_START: begin
        if (r < 5) return {junk[31:16], 12'hFFF, junk[3:0]};       // near a bank edge
        else if (r < 8) return {junk[31:24], 20'hFFFFF, junk[3:0]}; // near the 24-bit top
        else return junk;
      end
      REG_SRC_STRIDE, REG_DST_STRIDE: begin
        if (r < 3) return {junk[31:16], 16'hFFFF};
        else if (r < 5) return {junk[31:16], 16'h0000};
        else if (r < 10) return {junk[31:16], 8'h00, junk[7:0]};
        else return junk;
      end
      REG_WIDTH: begin
        if (r == 0) return {junk[31:12], 12'h000};
        else if (r == 1) return {junk[31:12], 12'hFFF};
        else if (r == 2) return {junk[31:12], 4'h0, junk[7:0]};
        else return {junk[31:12], 12'($urandom_range(1, 8))};
      end
      REG_HEIGHT: begin
        if (r == 0) return {junk[31:12], 12'h000};
        else if (r == 1) return {junk[31:12], 12'hFFF};
        else return {junk[31:12], 12'($urandom_range(1, 6))};
      end
      REG_DST_START: begin
        if (r < 5) return {28'hFFFFFFF, junk[3:0]};   // canvas address about to wrap
        else return junk;
      end
      default: return junk;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Drivers: change inputs on the falling edge only
  // --------------------------------------------------------------------------
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    note_reg(idx, val);
  endtask

  // Drop the pixel valid and hold until every owed result has come back
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
  endtask

  // Offer one pixel request, wait for the handshake, then log what it owes
  task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic typed,
                            input bbag_result_t known);
    int           gap;
    bbag_result_t predicted;
    gap = no_idle ? 0 : idle_len();
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      s_tdata  <= S_TDATA_W'($urandom);
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= pix;
    do @(posedge clk); while (!s_tready);
    predicted = blit_step(pix);
    pending_q.push_back(typed ? known : predicted);
  endtask

  // Address side: random stalls, plus one long hold when asked for
  initial begin : address_sink
    int sink_gap;
    sink_gap = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      if (sink_gap > 0) begin
        m_tready <= 1'b0;
        sink_gap--;
      end else begin
        m_tready <= 1'b1;
        if (!no_idle) sink_gap = idle_len();
      end
    end
  end

  // --------------------------------------------------------------------------
  // Checker: sample on the rising edge, compare with the oldest expectation
  // --------------------------------------------------------------------------
  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    bbag_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_q.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, got tdata %h user %b last %b",
                 $time, m_tdata, m_tuser, m_tlast);
        errors++;
      end else begin
        want = pending_q.pop_front();
        check_field("src_bank", 32'(want.src_bank), 32'(m_tdata[BANK_W-1:0]));
        check_field("src_offset", 32'(want.src_offset), 32'(m_tdata[BANK_W +: OFS_W]));
        check_field("dst_addr", want.dst_addr, m_tdata[BANK_W+OFS_W +: DST_ADDR_W]);
        check_field("pixel_out", 32'(want.pixel_out),
                    32'(m_tdata[BANK_W+OFS_W+DST_ADDR_W +: PIX_W]));
        check_field("write_enable", 32'(want.write_enable), 32'(m_tuser));
        check_field("last", 32'(want.last), 32'(m_tlast));
      end
    end
  end

  // Watchdog: count cycles in which nothing moves on any port
  always @(posedge clk) begin
    if (rst || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns: no transfer for %0d cycles, %0d results outstanding",
               $time, WATCHDOG_LIMIT, pending_q.size());
      $display("tb_top: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int               i;
    int               k;
    int               n_items;
    int               n_rand;
    int               area;
    bit               first_phase;
    bit               held;
    logic [PIX_W-1:0] p;
    stim_row_t        row;

    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    regs      = '0;
    col_cnt   = '0;
    row_cnt   = '0;
    row_src   = '0;
    row_dst   = '0;

    // Straight after reset every register is zero: an empty bitmap
    add_known(8'hFF, 8'h00, 16'h0000, 32'h0000_0000, 1'b0, 1'b1);

    // 4x2 transparent blit whose first row crosses a bank edge and the
    // canvas top; the out-of-range index must leave everything alone
    add_reg(REG_SRC_START, 32'h0000_FFFE);
    add_reg(REG_SRC_STRIDE, 32'h0000_FFFF);
    add_reg(REG_WIDTH, 32'd4);
    add_reg(REG_HEIGHT, 32'd2);
    add_reg(REG_DST_START, 32'hFFFF_FFFE);
    add_reg(REG_DST_STRIDE, 32'h0000_FFFF);
    add_reg(REG_TRANSPARENT, 32'd1);
    add_reg(REG_NONE, 32'hFFFF_FFFF);
    add_known(8'h00, 8'h00, 16'hFFFE, 32'hFFFF_FFFE, 1'b0, 1'b0);
    add_known(8'hFF, 8'h00, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 1'b0);
    add_known(8'h01, 8'h01, 16'h0000, 32'h0000_0000, 1'b1, 1'b0);
    add_known(8'h80, 8'h01, 16'h0001, 32'h0000_0001, 1'b1, 1'b0);
    add_pix(8'h7F);
    add_pix(8'h00);
    add_pix(8'h55);
    add_pix(8'hAA);

    // Source address wraps at 24 bits, opaque copy of a zero pixel
    add_reg(REG_SRC_START, 32'h00FF_FFFF);
    add_reg(REG_WIDTH, 32'd2);
    add_reg(REG_HEIGHT, 32'd1);
    add_reg(REG_TRANSPARENT, 32'd0);
    add_reg(REG_DST_START, 32'hFFFF_FFFF);
    add_known(8'h00, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 1'b0);
    add_known(8'h01, 8'h00, 16'h0000, 32'h0000_0000, 1'b1, 1'b1);

    // Zero height with full width: start position, no write, last
    add_reg(REG_WIDTH, 32'h0000_0FFF);
    add_reg(REG_HEIGHT, 32'd0);
    add_known(8'h3C, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, 1'b1);

    // Shrink width, then height, while a full-size blit is under way
    add_reg(REG_HEIGHT, 32'h0000_0FFF);
    add_reg(REG_SRC_START, 32'h0012_3456);
    add_reg(REG_DST_START, 32'h0000_1000);
    add_reg(REG_SRC_STRIDE, 32'h0000_0100);
    add_reg(REG_DST_STRIDE, 32'h0000_0200);
    add_reg(REG_TRANSPARENT, 32'd1);
    add_pix(8'h11);
    add_pix(8'h00);
    add_pix(8'h22);
    add_reg(REG_WIDTH, 32'd2);
    add_pix(8'h33);
    add_pix(8'h44);
    add_reg(REG_HEIGHT, 32'd1);
    add_pix(8'h55);
    add_pix(8'h66);
    add_pix(8'h77);

    // Zero strides: every row lands on the same addresses
    add_reg(REG_WIDTH, 32'd1);
    add_reg(REG_HEIGHT, 32'd3);
    add_reg(REG_SRC_STRIDE, 32'd0);
    add_reg(REG_DST_STRIDE, 32'd0);
    add_reg(REG_SRC_START, 32'd0);
    add_reg(REG_DST_START, 32'd0);
    add_known(8'h00, 8'h00, 16'h0000, 32'h0000_0000, 1'b0, 1'b0);
    add_known(8'hFF, 8'h00, 16'h0000, 32'h0000_0000, 1'b1, 1'b0);
    add_known(8'h00, 8'h00, 16'h0000, 32'h0000_0000, 1'b0, 1'b1);

    repeat (RST_CYCLES) @(negedge clk);
    rst <= 1'b0;

    // Walk the table; register writes wait for the block to go idle
    for (i = 0; i < directed_q.size(); i++) begin
      row = directed_q[i];
      if (row.kind == ROW_REG) begin
        drain();
        write_reg(row.idx, row.val);
      end else begin
        send_pixel(row.pix, row.typed, row.known);
      end
    end

    // Random phases: fresh register settings, then mostly whole blits
    n_rand      = 0;
    first_phase = 1'b1;
    held        = 1'b0;
    while (n_rand < RAND_PIXELS) begin
      drain();
      no_idle = ($urandom_range(0, 4) == 0);
      for (k = REG_SRC_START; k <= REG_NONE; k++) begin
        if (first_phase || ($urandom_range(0, 1) == 1))
          write_reg(CFG_ADDR_W'(k), reg_value(CFG_ADDR_W'(k)));
      end
      first_phase = 1'b0;

      area = int'(regs.width) * int'(regs.height);
      if (area != 0 && area <= 48 && col_cnt == '0 && row_cnt == '0 &&
          $urandom_range(0, 4) != 0) begin
        n_items = area * $urandom_range(1, 2);
      end else begin
        n_items = $urandom_range(1, 20);
      end

      // Once, stall the address side for a long stretch while pixels keep
      // coming, so the block fills up and pushes back on its input
      if (!held && n_rand >= RAND_PIXELS / 3) begin
        held     = 1'b1;
        no_idle  = 1'b1;
        n_items  = 40;
        hold_req = 1'b1;
      end

      repeat (n_items) begin
        p = ($urandom_range(0, 3) == 0) ? 8'h00 : PIX_W'($urandom_range(0, 255));
        send_pixel(p, 1'b0, '0);
        n_rand++;
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

// ===== banked_bitmap_blit_address_gen.f =====
rtl/core/bbag_pkg.sv
rtl/core/bbag_step.sv
rtl/core/banked_bitmap_blit_address_gen.sv
dv/tb_top.sv
